// ----- sv/sha256_pkg.sv -----
`timescale 1ns / 1ps

package sha256_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned Rounds  = 64;
  localparam int unsigned BlkWrds = 16;
  localparam int unsigned HashWrds = 8;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    logic [31:0] message_word;
    logic        start_message;
    logic        final_block;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_word_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t iv_word(input logic [2:0] idx);
    word_t r;
    unique case (idx)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      3'd7: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic word_t k_word(input logic [5:0] idx);
    word_t r;
    unique case (idx)
      6'd0:  r = 32'h428a2f98;
      6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf;
      6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b;
      6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4;
      6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98;
      6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be;
      6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74;
      6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1;
      6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6;
      6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc;
      6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152;
      6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3;
      6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351;
      6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc;
      6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354;
      6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1;
      6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70;
      6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585;
      6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116;
      6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3;
      6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f;
      6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814;
      6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa;
      6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;
      6'd63: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/sha256_block_compression.sv -----
`timescale 1ns / 1ps
// Words are taken only while loading (in_ready high), none while a block is
// compressed. The sixteenth word starts 64 rounds on the shared round unit,
// then a hash update, for each 512-bit block of 16 words.
// A final block then presents eight digest words, one per out_ready cycle.
// Reset (rst_n low, synchronous) loads the initial hash and clears counters.
module sha256_block_compression (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sha256_pkg::in_word_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sha256_pkg::out_word_t out_data
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROUND,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  state_t                state_r, state_nxt;
  logic [3:0]            word_cnt_r, word_cnt_nxt;
  logic [5:0]            round_r, round_nxt;
  logic [2:0]            emit_idx_r, emit_idx_nxt;
  logic                  final_r, final_nxt;
  logic                  out_valid_r, out_valid_nxt;
  sha256_pkg::out_word_t out_data_r, out_data_nxt;
  sha256_pkg::word_t     h_r [sha256_pkg::HashWrds];
  sha256_pkg::word_t     h_nxt [sha256_pkg::HashWrds];
  sha256_pkg::word_t     v_r [sha256_pkg::HashWrds];
  sha256_pkg::word_t     v_nxt [sha256_pkg::HashWrds];
  sha256_pkg::word_t     w_r [sha256_pkg::BlkWrds];
  sha256_pkg::word_t     w_nxt [sha256_pkg::BlkWrds];

  sha256_pkg::word_t     t1, t2, w_new;
  logic [3:0]            slot;
  logic [2:0]            emit_next_idx;

  assign in_ready  = (state_r == ST_LOAD);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // shared round unit
  always_comb begin
    t1 = v_r[7] + sha256_pkg::big_sigma1(v_r[4])
       + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
       + sha256_pkg::k_word(round_r) + w_r[0];
    t2 = sha256_pkg::big_sigma0(v_r[0])
       + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
    w_new = w_r[0] + sha256_pkg::small_sigma0(w_r[1]) + w_r[9]
          + sha256_pkg::small_sigma1(w_r[14]);
  end

  assign slot          = in_data.start_message ? 4'd0 : word_cnt_r;
  assign emit_next_idx = emit_idx_r + 3'd1;

  always_comb begin
    state_nxt     = state_r;
    word_cnt_nxt  = word_cnt_r;
    round_nxt     = round_r;
    emit_idx_nxt  = emit_idx_r;
    final_nxt     = final_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    h_nxt         = h_r;
    v_nxt         = v_r;
    w_nxt         = w_r;

    unique case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          if (in_data.start_message) begin
            for (int i = 0; i < sha256_pkg::HashWrds; i++) begin
              h_nxt[i] = sha256_pkg::iv_word(3'(i));
            end
          end
          for (int i = 0; i < sha256_pkg::BlkWrds - 1; i++) begin
            w_nxt[i] = w_r[i+1];
          end
          w_nxt[sha256_pkg::BlkWrds-1] = in_data.message_word;
          if (slot == 4'd15) begin
            word_cnt_nxt = 4'd0;
            final_nxt    = in_data.final_block;
            round_nxt    = 6'd0;
            v_nxt        = h_r;
            state_nxt    = ST_ROUND;
          end else begin
            word_cnt_nxt = slot + 4'd1;
          end
        end
      end
      ST_ROUND: begin
        v_nxt[7] = v_r[6];
        v_nxt[6] = v_r[5];
        v_nxt[5] = v_r[4];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[3] = v_r[2];
        v_nxt[2] = v_r[1];
        v_nxt[1] = v_r[0];
        v_nxt[0] = t1 + t2;
        for (int i = 0; i < sha256_pkg::BlkWrds - 1; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[sha256_pkg::BlkWrds-1] = w_new;
        round_nxt = round_r + 6'd1;
        if (round_r == 6'(sha256_pkg::Rounds - 1)) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        for (int i = 0; i < sha256_pkg::HashWrds; i++) begin
          h_nxt[i] = h_r[i] + v_r[i];
        end
        if (final_r) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.digest_word = h_r[0] + v_r[0];
          out_data_nxt.word_index  = 3'd0;
          out_data_nxt.last_word   = 1'b0;
          emit_idx_nxt             = 3'd0;
          state_nxt                = ST_EMIT;
        end else begin
          state_nxt = ST_LOAD;
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          if (emit_idx_r == 3'd7) begin
            out_valid_nxt = 1'b0;
            state_nxt     = ST_LOAD;
          end else begin
            emit_idx_nxt             = emit_next_idx;
            out_data_nxt.digest_word = h_r[emit_next_idx];
            out_data_nxt.word_index  = emit_next_idx;
            out_data_nxt.last_word   = (emit_next_idx == 3'd7);
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      word_cnt_r  <= 4'd0;
      round_r     <= 6'd0;
      emit_idx_r  <= 3'd0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
      for (int i = 0; i < sha256_pkg::HashWrds; i++) begin
        h_r[i] <= sha256_pkg::iv_word(3'(i));
        v_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      word_cnt_r  <= word_cnt_nxt;
      round_r     <= round_nxt;
      emit_idx_r  <= emit_idx_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
      h_r         <= h_nxt;
      v_r         <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
  end

endmodule
